// ----- src/q8dp_pkg.sv -----
// ----------------------------------------------------------------------------
// q8dp_pkg
// types, constants and fp32 arithmetic for the q8 block dot product
// ----------------------------------------------------------------------------
package q8dp_pkg;

   localparam int LANES  = 4;
   localparam int LEVELS = (LANES > 1) ? $clog2(LANES) : 0;
   localparam logic [31:0] QNAN = 32'h7FC0_0000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIN
   } state_type;

   typedef logic [31:0] f32_type;

   function automatic int node_cnt(input int lvl);
      return (LANES + (1 << lvl) - 1) >> lvl;
   endfunction

   function automatic logic is_nan(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   function automatic logic [31:0] half_to_f32(input logic [15:0] h);
      logic [31:0] r;
      logic [3:0]  p;
      logic [9:0]  m;
      logic [22:0] frac;
      begin
         r = 32'd0;
         p = 4'd0;
         m = h[9:0];
         frac = 23'd0;
         if (h[14:10] == 5'd0) begin
            if (m == 10'd0) begin
               r = {h[15], 31'd0};
            end else begin
               for (int i = 0; i < 10; i++) begin
                  if (m[i]) begin
                     p = 4'(i);
                  end
               end
               frac = 23'({13'd0, m} << (5'd23 - {1'b0, p}));
               r = {h[15], 8'(8'd103 + {4'd0, p}), frac};
            end
         end else if (h[14:10] == 5'h1F) begin
            r = {h[15], 8'hFF, m, 13'd0};
         end else begin
            r = {h[15], 8'({3'd0, h[14:10]} + 8'd112), m, 13'd0};
         end
         return r;
      end
   endfunction

   function automatic logic [31:0] i8_to_f32(input logic signed [7:0] q);
      logic [7:0]  mag;
      logic [2:0]  p;
      logic [22:0] frac;
      logic [31:0] r;
      begin
         mag = q[7] ? 8'(-q) : 8'(q);
         p = 3'd0;
         r = 32'd0;
         for (int i = 0; i < 8; i++) begin
            if (mag[i]) begin
               p = 3'(i);
            end
         end
         frac = 23'({15'd0, mag} << (5'd23 - {2'b0, p}));
         if (mag != 8'd0) begin
            r = {q[7], 8'(8'd127 + {5'd0, p}), frac};
         end
         return r;
      end
   endfunction

   function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
      logic               s;
      logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic [7:0]         ea, eb;
      logic [23:0]        ma, mb;
      logic [47:0]        prod, nrm, shd;
      logic [5:0]         lz;
      logic               found;
      logic signed [10:0] e;
      logic signed [10:0] shs;
      logic [5:0]         sh;
      logic [9:0]         ebase;
      logic               g, stk, rnd;
      logic [33:0]        pk;
      logic [31:0]        r;
      begin
         s = a[31] ^ b[31];
         a_nan = is_nan(a);
         b_nan = is_nan(b);
         a_inf = (a[30:0] == 31'h7F80_0000);
         b_inf = (b[30:0] == 31'h7F80_0000);
         a_zero = (a[30:0] == 31'd0);
         b_zero = (b[30:0] == 31'd0);
         ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
         eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
         ma = {a[30:23] != 8'd0, a[22:0]};
         mb = {b[30:23] != 8'd0, b[22:0]};
         prod = ma * mb;
         lz = 6'd0;
         found = 1'b0;
         for (int i = 47; i >= 0; i--) begin
            if (!found && prod[i]) begin
               lz = 6'(47 - i);
               found = 1'b1;
            end
         end
         nrm = prod << lz;
         e = 11'(signed'({3'd0, ea})) + 11'(signed'({3'd0, eb})) - 11'sd126
             - 11'(signed'({5'd0, lz}));
         if (e < 11'sd1) begin
            shs = 11'sd1 - e;
            sh = (shs > 11'sd50) ? 6'd50 : shs[5:0];
            ebase = 10'd1;
         end else begin
            shs = 11'sd0;
            sh = 6'd0;
            ebase = e[9:0];
         end
         shd = nrm >> sh;
         stk = |(nrm & ~({48{1'b1}} << sh));
         g = shd[23];
         stk = stk | (|shd[22:0]);
         rnd = g & (stk | shd[24]);
         pk = ((34'(ebase) - 34'd1) << 23) + 34'(shd[47:24]) + 34'(rnd);
         if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            r = QNAN;
         end else if (a_inf || b_inf) begin
            r = {s, 31'h7F80_0000};
         end else if (a_zero || b_zero) begin
            r = {s, 31'd0};
         end else if (pk >= 34'h7F80_0000) begin
            r = {s, 31'h7F80_0000};
         end else begin
            r = {s, pk[30:0]};
         end
         return r;
      end
   endfunction

   function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] x, y, r;
      logic        a_nan, b_nan, a_inf, b_inf;
      logic [7:0]  ex, ey, d;
      logic [26:0] mx, my, shf;
      logic        stk, g, rnd, found;
      logic [27:0] sm;
      logic [4:0]  lz;
      logic [9:0]  ebase;
      logic [23:0] mant;
      logic [33:0] pk;
      begin
         a_nan = is_nan(a);
         b_nan = is_nan(b);
         a_inf = (a[30:0] == 31'h7F80_0000);
         b_inf = (b[30:0] == 31'h7F80_0000);
         if (a[30:0] >= b[30:0]) begin
            x = a;
            y = b;
         end else begin
            x = b;
            y = a;
         end
         ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
         ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
         mx = {x[30:23] != 8'd0, x[22:0], 3'd0};
         my = {y[30:23] != 8'd0, y[22:0], 3'd0};
         d = ex - ey;
         if (d > 8'd27) begin
            shf = 27'd0;
            stk = |my;
         end else begin
            shf = my >> d;
            stk = |(my & ~({27{1'b1}} << d));
         end
         shf = shf | {26'd0, stk};
         if (x[31] ^ y[31]) begin
            sm = {1'b0, mx} - {1'b0, shf};
         end else begin
            sm = {1'b0, mx} + {1'b0, shf};
         end
         lz = 5'd0;
         found = 1'b0;
         if (sm[27]) begin
            sm = {1'b0, sm[27:2], sm[1] | sm[0]};
            ebase = 10'({2'd0, ex}) + 10'd1;
         end else begin
            for (int i = 26; i >= 0; i--) begin
               if (!found && sm[i]) begin
                  lz = 5'(26 - i);
                  found = 1'b1;
               end
            end
            if ({2'd0, ex} > {5'd0, lz}) begin
               sm = sm << lz;
               ebase = 10'({2'd0, ex}) - 10'({5'd0, lz});
            end else begin
               sm = sm << (ex - 8'd1);
               ebase = 10'd1;
            end
         end
         mant = sm[26:3];
         g = sm[2];
         rnd = g & (sm[1] | sm[0] | mant[0]);
         pk = ((34'(ebase) - 34'd1) << 23) + 34'(mant) + 34'(rnd);
         if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
            r = QNAN;
         end else if (a_inf) begin
            r = a;
         end else if (b_inf) begin
            r = b;
         end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
            r = {a[31] & b[31], 31'd0};
         end else if (sm == 28'd0) begin
            r = 32'd0;
         end else if (pk >= 34'h7F80_0000) begin
            r = {x[31], 31'h7F80_0000};
         end else begin
            r = {x[31], pk[30:0]};
         end
         return r;
      end
   endfunction

endpackage

// ----- src/q8dp_lane.sv -----
// ----------------------------------------------------------------------------
// q8dp_lane
// one lane: weight = scale * q, then product = weight * activation
// ----------------------------------------------------------------------------
module q8dp_lane
   import q8dp_pkg::*;
(
   input  logic              clock,
   input  logic              load,
   input  logic [31:0]       scale_f32,
   input  logic signed [7:0] quant,
   input  logic [31:0]       act,
   output logic [31:0]       prod
);

   logic [31:0] w_ff, w_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] p_ff, p_in;

   always_comb begin
      w_in = load ? f_mul(scale_f32, i8_to_f32(quant)) : w_ff;
      a_in = load ? act : a_ff;
      p_in = f_mul(w_ff, a_ff);
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      a_ff <= a_in;
      p_ff <= p_in;
   end

   assign prod = p_ff;

endmodule

// ----- src/q8dp_tree.sv -----
// ----------------------------------------------------------------------------
// q8dp_tree
// registered pairwise adder tree merging the lane products
// ----------------------------------------------------------------------------
module q8dp_tree
   import q8dp_pkg::*;
(
   input  logic        clock,
   input  f32_type     prod [LANES],
   output logic [31:0] sum
);

   f32_type lvl [1:LEVELS][LANES];

   for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
      f32_type src [LANES];

      if (l == 1) begin : g_first
         assign src = prod;
      end else begin : g_next
         assign src = lvl[l-1];
      end

      always_ff @(posedge clock) begin
         for (int i = 0; i < LANES; i++) begin
            if (2 * i + 1 < node_cnt(l - 1)) begin
               lvl[l][i] <= f_add(src[2*i], src[2*i+1]);
            end else if (2 * i < node_cnt(l - 1)) begin
               lvl[l][i] <= src[2*i];
            end else begin
               lvl[l][i] <= 32'd0;
            end
         end
      end
   end

   assign sum = lvl[LEVELS][0];

endmodule

// ----- src/q8_block_dot_product_bias.sv -----
// ----------------------------------------------------------------------------
// q8_block_dot_product_bias
// streaming dot product of q8 weight blocks with fp32 activations
// ----------------------------------------------------------------------------
// Each item holds one fp16 block scale, four int8 weights and four fp32
// activations. Four lanes form scale*q and multiply by the activation, a
// registered pairwise tree merges the products and one fp32 adder folds the
// item sum into the accumulator. An item passes through the weight multiply,
// activation multiply, two tree levels and accumulate; the last item of a row
// then adds the bias (only when the csr bit enables it) and waits while an
// earlier result is still stalled. Results are IEEE fp32, round to nearest
// even, NaN as 0x7FC00000.
// ----------------------------------------------------------------------------
module q8_block_dot_product_bias
   import q8dp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [15:0]       req_scale_half,
   input  logic signed [7:0] req_quant_0,
   input  logic signed [7:0] req_quant_1,
   input  logic signed [7:0] req_quant_2,
   input  logic signed [7:0] req_quant_3,
   input  logic [31:0]       req_act_0,
   input  logic [31:0]       req_act_1,
   input  logic [31:0]       req_act_2,
   input  logic [31:0]       req_act_3,
   input  logic [31:0]       req_bias_bits,
   input  logic              req_row_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_dot_result,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);

   localparam int RUN_END = LEVELS + 1;
   localparam int CNT_W   = $clog2(RUN_END + 2);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [31:0]        acc_ff, acc_in;
   logic [31:0]        bias_ff, bias_in;
   logic               last_ff, last_in;
   logic               bias_en_ff, bias_en_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               run_done;
   logic               out_free;
   logic               acc_load, acc_clear, rsp_load;
   logic [31:0]        scale_f32;
   logic signed [7:0]  quant [LANES];
   f32_type            act [LANES];
   f32_type            prod [LANES];
   logic [31:0]        item_sum;
   logic [31:0]        final_sum;

   assign accept    = req_valid && !req_stall;
   assign run_done  = (cnt_ff == CNT_W'(RUN_END));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scale_f32 = half_to_f32(req_scale_half);

   assign quant[0] = req_quant_0;
   assign quant[1] = req_quant_1;
   assign quant[2] = req_quant_2;
   assign quant[3] = req_quant_3;
   assign act[0]   = req_act_0;
   assign act[1]   = req_act_1;
   assign act[2]   = req_act_2;
   assign act[3]   = req_act_3;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      q8dp_lane u_lane (
         .clock     (clock),
         .load      (accept),
         .scale_f32 (scale_f32),
         .quant     (quant[i]),
         .act       (act[i]),
         .prod      (prod[i])
      );
   end

   q8dp_tree u_tree (
      .clock (clock),
      .prod  (prod),
      .sum   (item_sum)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (run_done) begin
               state_in = last_ff ? ST_FIN : ST_IDLE;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      acc_load  = 1'b0;
      acc_clear = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_RUN:  acc_load  = run_done;
         ST_FIN: begin
            acc_clear = out_free;
            rsp_load  = out_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

   assign final_sum = bias_en_ff ? f_add(acc_ff, bias_ff) : acc_ff;

   always_comb begin
      cnt_in       = (state_ff == ST_RUN) ? cnt_ff + CNT_W'(1) : '0;
      acc_in       = acc_clear ? 32'd0 : (acc_load ? f_add(acc_ff, item_sum) : acc_ff);
      bias_in      = accept ? req_bias_bits : bias_ff;
      last_in      = accept ? req_row_last : last_ff;
      bias_en_in   = csr_write_enable ? csr_write_data : bias_en_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_load ? (is_nan(final_sum) ? QNAN : final_sum) : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         acc_ff       <= 32'd0;
         bias_en_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         bias_en_ff   <= bias_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bias_ff     <= bias_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dot_result = rsp_data_ff;

endmodule
